[design/lsws_pkg.sv]
// Package: sizes, codes and shared types of the LIFO stack with reverse and search.
`timescale 1ns / 1ps
`default_nettype none
package lsws_pkg;

    localparam int DEPTH  = 16;
    localparam int AW     = $clog2(DEPTH);
    localparam int CW     = $clog2(DEPTH + 1);
    localparam int DATA_W = 32;

    localparam logic [1:0] OP_PUSH    = 2'd0;
    localparam logic [1:0] OP_POP     = 2'd1;
    localparam logic [1:0] OP_REVERSE = 2'd2;
    localparam logic [1:0] OP_SEARCH  = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_UNDER = 2'd1;
    localparam logic [1:0] ST_OVER  = 2'd2;

    typedef struct packed {
        logic              wr_en;
        logic [AW-1:0]     wr_addr;
        logic [DATA_W-1:0] wr_data;
        logic              rd_en;
        logic [AW-1:0]     rd_addr;
    } mem_req_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] popped_value;
        logic [CW-1:0]            match_position;
        logic [1:0]               status;
        logic [CW-1:0]            entry_count;
    } result_t;

endpackage
`default_nettype wire

[design/stack_with_reverse_and_search_unit.sv]
// Top level: LIFO stack of signed 32-bit values with push, pop, reverse and search.
// A request passes the execute state, for pop the read-wait state, for search the
// search state until a match or the fill count, then the finish state, which waits
// until the result is loaded into the output register; only then is a new request taken.
// Reset (rst_n, async, active low) empties the stack and clears the direction bit.
// Stack entries themselves are not cleared; only entries below the fill count are read.
`timescale 1ns / 1ps
`default_nettype none
module stack_with_reverse_and_search_unit (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire logic [1:0]                          opcode,
    input  wire logic signed [lsws_pkg::DATA_W-1:0]  operand_value,
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic signed [lsws_pkg::DATA_W-1:0]       popped_value,
    output logic [lsws_pkg::CW-1:0]                  match_position,
    output logic [1:0]                               status,
    output logic [lsws_pkg::CW-1:0]                  entry_count
);
    import lsws_pkg::*;

    mem_req_t          mem_req;
    logic [DATA_W-1:0] mem_rd_data;
    result_t           res;

    lsws_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram (
        .clk     (clk),
        .wr_en   (mem_req.wr_en),
        .wr_addr (mem_req.wr_addr),
        .wr_data (mem_req.wr_data),
        .rd_en   (mem_req.rd_en),
        .rd_addr (mem_req.rd_addr),
        .rd_data (mem_rd_data)
    );

    lsws_seq u_seq (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .opcode        (opcode),
        .operand_value (operand_value),
        .mem_req       (mem_req),
        .mem_rd_data   (mem_rd_data),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_res       (res)
    );

    assign popped_value   = res.popped_value;
    assign match_position = res.match_position;
    assign status         = res.status;
    assign entry_count    = res.entry_count;

endmodule
`default_nettype wire

[design/lsws_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module lsws_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

[design/lsws_seq.sv]
// Sequencer: ring pointers, request execution, serial search compare and output register.
`timescale 1ns / 1ps
`default_nettype none
module lsws_seq (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire logic [1:0]                      opcode,
    input  wire logic signed [lsws_pkg::DATA_W-1:0] operand_value,
    output lsws_pkg::mem_req_t                   mem_req,
    input  wire logic [lsws_pkg::DATA_W-1:0]     mem_rd_data,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output lsws_pkg::result_t                    out_res
);
    import lsws_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EXEC = 3'd1;
    localparam logic [2:0] S_POPW = 3'd2;
    localparam logic [2:0] S_SRCH = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;

    logic [2:0]        state_reg, state_next;
    logic [1:0]        op_reg;
    logic [DATA_W-1:0] key_reg;
    logic [CW-1:0]     fill_reg, fill_next;
    logic [AW-1:0]     base_reg, base_next;
    logic              rev_reg, rev_next;
    logic [CW-1:0]     k_reg, k_next;
    result_t           res_reg, res_next;
    result_t           out_res_reg;
    logic              out_valid_reg;
    logic              out_load;

    // ring address of the entry at 1-based position k from the top
    function automatic logic [AW-1:0] phys_of(input logic [AW-1:0] base,
                                              input logic [CW-1:0] fill,
                                              input logic          rev,
                                              input logic [CW-1:0] k);
        logic [CW-1:0] off;
        logic [AW:0]   s;
        off = rev ? (k - CW'(1)) : (fill - k);
        s   = (AW+1)'(base) + (AW+1)'(off);
        if (s >= (AW+1)'(DEPTH))
        begin
            s = s - (AW+1)'(DEPTH);
        end
        return s[AW-1:0];
    endfunction

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;
    assign out_load  = (state_reg == S_FIN) && (!out_valid_reg || out_ready);

    always_comb
    begin
        state_next = state_reg;
        fill_next  = fill_reg;
        base_next  = base_reg;
        rev_next   = rev_reg;
        k_next     = k_reg;
        res_next   = res_reg;
        mem_req    = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_EXEC;
                    res_next   = '0;
                end
            end
            S_EXEC:
            begin
                case (op_reg)
                    OP_PUSH:
                    begin
                        state_next = S_FIN;
                        if (fill_reg == CW'(DEPTH))
                        begin
                            res_next.status = ST_OVER;
                        end
                        else
                        begin
                            mem_req.wr_en   = 1'b1;
                            mem_req.wr_data = key_reg;
                            fill_next       = fill_reg + CW'(1);
                            if (rev_reg)
                            begin
                                base_next = (base_reg == '0) ? AW'(DEPTH - 1)
                                                             : base_reg - AW'(1);
                                mem_req.wr_addr = base_next;
                            end
                            else
                            begin
                                mem_req.wr_addr = phys_of(base_reg, fill_reg, 1'b1,
                                                          fill_reg + CW'(1));
                            end
                        end
                    end
                    OP_POP:
                    begin
                        if (fill_reg == '0)
                        begin
                            res_next.status = ST_UNDER;
                            state_next      = S_FIN;
                        end
                        else
                        begin
                            mem_req.rd_en   = 1'b1;
                            mem_req.rd_addr = phys_of(base_reg, fill_reg, rev_reg, CW'(1));
                            state_next      = S_POPW;
                        end
                    end
                    OP_REVERSE:
                    begin
                        rev_next   = !rev_reg;
                        state_next = S_FIN;
                    end
                    default:
                    begin
                        if (fill_reg == '0)
                        begin
                            state_next = S_FIN;
                        end
                        else
                        begin
                            mem_req.rd_en   = 1'b1;
                            mem_req.rd_addr = phys_of(base_reg, fill_reg, rev_reg, CW'(1));
                            k_next          = CW'(1);
                            state_next      = S_SRCH;
                        end
                    end
                endcase
            end
            S_POPW:
            begin
                res_next.popped_value = mem_rd_data;
                fill_next             = fill_reg - CW'(1);
                if (rev_reg)
                begin
                    base_next = (base_reg == AW'(DEPTH - 1)) ? '0 : base_reg + AW'(1);
                end
                state_next = S_FIN;
            end
            S_SRCH:
            begin
                // compare entry k while fetching entry k+1
                if (mem_rd_data == key_reg)
                begin
                    res_next.match_position = k_reg;
                    state_next              = S_FIN;
                end
                else if (k_reg == fill_reg)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = phys_of(base_reg, fill_reg, rev_reg, k_reg + CW'(1));
                    k_next          = k_reg + CW'(1);
                end
            end
            S_FIN:
            begin
                res_next.entry_count = fill_reg;
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            fill_reg      <= '0;
            base_reg      <= '0;
            rev_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            base_reg  <= base_next;
            rev_reg   <= rev_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            op_reg  <= opcode;
            key_reg <= operand_value;
        end
        k_reg   <= k_next;
        res_reg <= res_next;
        if (out_load)
        begin
            out_res_reg <= res_next;
        end
    end

endmodule
`default_nettype wire

[design/lsws_checker.sv]
// Port-level checker for the stack unit, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module lsws_checker (
    input wire logic                                clk,
    input wire logic                                rst_n,
    input wire logic                                in_valid,
    input wire logic                                in_ready,
    input wire logic                                out_valid,
    input wire logic signed [lsws_pkg::DATA_W-1:0]  popped_value,
    input wire logic [lsws_pkg::CW-1:0]             match_position,
    input wire logic [1:0]                          status,
    input wire logic [lsws_pkg::CW-1:0]             entry_count
);
    import lsws_pkg::*;

    a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input ready right after a transfer");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (entry_count <= CW'(DEPTH)))
        else $error("entry count beyond depth");

    a_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == ST_UNDER) |-> (popped_value == '0 && entry_count == '0))
        else $error("underflow result inconsistent");

    a_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == ST_OVER) |-> (entry_count == CW'(DEPTH)))
        else $error("overflow reported while not full");

    a_match_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (match_position <= entry_count))
        else $error("match position beyond entry count");

endmodule

bind stack_with_reverse_and_search_unit lsws_checker u_lsws_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .out_valid      (out_valid),
    .popped_value   (popped_value),
    .match_position (match_position),
    .status         (status),
    .entry_count    (entry_count)
);
`default_nettype wire

[sim/stack_with_reverse_and_search_unit_test.sv]
// Testbench: LIFO stack with reverse and search, checked transfer by transfer against a predictor.
`timescale 1ns / 1ps
module stack_with_reverse_and_search_unit_test;
    import lsws_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    class stack_scoreboard;
        logic [DATA_W-1:0] ring [DEPTH];
        int unsigned       depth_used;
        logic [AW-1:0]     base;
        bit                flipped;
        result_t           pending [$];
        int unsigned       errors;

        function new();
            foreach (ring[i])
                ring[i] = '0;
            depth_used = 0;
            base       = '0;
            flipped    = 1'b0;
            errors     = 0;
        endfunction

        // ring slot of logical entry i, 0 being the bottom
        function automatic logic [AW-1:0] slot_of(int unsigned i);
            int unsigned   off;
            logic [AW-1:0] idx;
            off = flipped ? depth_used - 1 - i : i;
            idx = base + AW'(off);
            return idx;
        endfunction

        function automatic void note_request(logic [1:0] op, logic signed [DATA_W-1:0] val);
            result_t       r;
            logic [AW-1:0] idx;
            r = '0;
            case (op)
                OP_PUSH:
                    if (depth_used >= DEPTH)
                        r.status = ST_OVER;
                    else begin
                        if (flipped) begin
                            base = base - 1'b1;
                            idx  = base;
                        end else
                            idx = base + AW'(depth_used);
                        ring[idx] = val;
                        depth_used++;
                    end
                OP_POP:
                    if (depth_used == 0)
                        r.status = ST_UNDER;
                    else begin
                        r.popped_value = ring[slot_of(depth_used - 1)];
                        if (flipped)
                            base = base + 1'b1;
                        depth_used--;
                    end
                OP_REVERSE:
                    flipped = !flipped;
                default:
                    for (int unsigned k = 1; k <= depth_used; k++) begin
                        if (ring[slot_of(depth_used - k)] == val) begin
                            r.match_position = CW'(k);
                            break;
                        end
                    end
            endcase
            r.entry_count = CW'(depth_used);
            pending.push_back(r);
        endfunction

        function automatic void check_result(result_t got);
            result_t exp;
            if (pending.size() == 0) begin
                $error("unexpected result transfer: popped_value %0d status %0d",
                       got.popped_value, got.status);
                errors++;
                return;
            end
            exp = pending.pop_front();
            if (got.popped_value !== exp.popped_value) begin
                $error("popped_value: expected %0d, actual %0d", exp.popped_value,
                       got.popped_value);
                errors++;
            end
            if (got.match_position !== exp.match_position) begin
                $error("match_position: expected %0d, actual %0d", exp.match_position,
                       got.match_position);
                errors++;
            end
            if (got.status !== exp.status) begin
                $error("status: expected %0d, actual %0d", exp.status, got.status);
                errors++;
            end
            if (got.entry_count !== exp.entry_count) begin
                $error("entry_count: expected %0d, actual %0d", exp.entry_count,
                       got.entry_count);
                errors++;
            end
        endfunction
    endclass

    logic                     clk           = 1'b0;
    logic                     rst_n         = 1'b0;
    logic                     in_valid      = 1'b0;
    logic [1:0]               opcode        = OP_PUSH;
    logic signed [DATA_W-1:0] operand_value = '0;
    logic                     out_ready     = 1'b0;
    logic                     in_ready;
    logic                     out_valid;
    logic signed [DATA_W-1:0] popped_value;
    logic [CW-1:0]            match_position;
    logic [1:0]               status;
    logic [CW-1:0]            entry_count;

    stack_scoreboard          sb;
    int                       send_idle_pct  = 0;
    int                       recv_stall_pct = 0;
    bit                       pause_start    = 1'b0;
    int                       hold_left      = 0;
    int                       cycle_count    = 0;
    logic signed [DATA_W-1:0] recent_pushes [$];
    logic signed [DATA_W-1:0] value_pool [6];

    stack_with_reverse_and_search_unit DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .opcode         (opcode),
        .operand_value  (operand_value),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .popped_value   (popped_value),
        .match_position (match_position),
        .status         (status),
        .entry_count    (entry_count)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // receiver: random stalls, plus a long hold-off on request
    always @(posedge clk)
    begin
        if (pause_start) begin
            hold_left   = 300;
            pause_start = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_ready <= 1'b0;
        end else
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        result_t got;
        if (rst_n && out_valid && out_ready) begin
            got.popped_value   = popped_value;
            got.match_position = match_position;
            got.status         = status;
            got.entry_count    = entry_count;
            sb.check_result(got);
        end
    end

    task automatic send_request(input logic [1:0] op, input logic signed [DATA_W-1:0] val);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid      <= 1'b1;
        opcode        <= op;
        operand_value <= val;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_request(op, val);
        if (op == OP_PUSH) begin
            recent_pushes.push_back(val);
            if (recent_pushes.size() > 16)
                void'(recent_pushes.pop_front());
        end
    endtask

    function automatic logic signed [DATA_W-1:0] pick_value();
        if ($urandom_range(1) == 0)
            return value_pool[$urandom_range(5)];
        return $urandom;
    endfunction

    function automatic logic signed [DATA_W-1:0] pick_key();
        if (recent_pushes.size() != 0 && $urandom_range(99) < 60)
            return recent_pushes[$urandom_range(recent_pushes.size() - 1)];
        return pick_value();
    endfunction

    function automatic logic [1:0] pick_op(bit filling);
        int roll;
        roll = $urandom_range(99);
        if (roll < 20)
            return OP_SEARCH;
        if (roll < 30)
            return OP_REVERSE;
        if (roll < (filling ? 85 : 45))
            return OP_PUSH;
        return OP_POP;
    endfunction

    task automatic run_random(input int count);
        logic [1:0] op;
        for (int n = 0; n < count; n++) begin
            op = pick_op((n / 40) % 2 == 0);
            case (op)
                OP_PUSH:   send_request(op, pick_value());
                OP_SEARCH: send_request(op, pick_key());
                default:   send_request(op, $urandom);
            endcase
        end
    endtask

    initial
    begin
        sb = new();
        value_pool[0] = 32'sh8000_0000;
        value_pool[1] = 32'sh7fff_ffff;
        value_pool[2] = '0;
        value_pool[3] = -32'sd1;
        value_pool[4] = $urandom;
        value_pool[5] = $urandom;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes, every opcode, empty and reversed corners
        send_request(OP_PUSH, 32'sh8000_0000);
        send_request(OP_PUSH, 32'sh7fff_ffff);
        send_request(OP_PUSH, '0);
        send_request(OP_PUSH, -32'sd1);
        send_request(OP_PUSH, 32'sd1);
        send_request(OP_SEARCH, 32'sh7fff_ffff);
        send_request(OP_SEARCH, -32'sd1);
        send_request(OP_SEARCH, 32'sd12345);
        send_request(OP_REVERSE, '0);
        send_request(OP_SEARCH, 32'sh8000_0000);
        send_request(OP_POP, '0);
        send_request(OP_PUSH, 32'sd7);
        send_request(OP_POP, 32'sh5555_aaaa);
        send_request(OP_REVERSE, -32'sd1);
        repeat (4) send_request(OP_POP, '0);
        send_request(OP_POP, '0);
        send_request(OP_SEARCH, '0);
        send_request(OP_REVERSE, '0);

        // long receiver hold-off while filling past full
        pause_start = 1'b1;
        for (int i = 0; i <= DEPTH; i++)
            send_request(OP_PUSH, (i == 0) ? 32'sh1357_9bdf : pick_value());
        send_request(OP_SEARCH, 32'sh1357_9bdf);
        send_request(OP_SEARCH, 32'sh2468_ace0);

        run_random(135);
        send_idle_pct  = 76;
        run_random(135);
        send_idle_pct  = 0;
        recv_stall_pct = 76;
        run_random(135);
        send_idle_pct  = 15;
        recv_stall_pct = 15;
        run_random(135);
        in_valid <= 1'b0;

        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
        if (sb.errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

[files.f]
design/lsws_pkg.sv
design/lsws_ram.sv
design/lsws_seq.sv
design/stack_with_reverse_and_search_unit.sv
design/lsws_checker.sv
sim/stack_with_reverse_and_search_unit_test.sv
